// ===== rtl/core/gra_pkg.sv =====
// ----------------------------------------------------------------------------
// gra_pkg
// Shared types and constants of the grid rectangle allocator: word layouts,
// operation and status codes, controller states and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gra_pkg;

   localparam int FUNC_W     = 3;
   localparam int POS_W      = 6;
   localparam int WID_W      = 5;
   localparam int HGT_W      = 7;
   localparam int TID_W      = 12;
   localparam int STAT_W     = 3;
   localparam int FCOL_W     = 4;
   localparam int FROW_W     = 6;
   localparam int USED_W     = 11;
   localparam int COLS_REG_W = 5;
   localparam int ROWS_REG_W = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int SUM_W      = 10;

   localparam logic [FUNC_W-1:0] FUNC_PLACE  = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_AUTO   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_MOVE   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS    = 1'd1;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK,
      STAT_BOUNDS,
      STAT_NO_FIT,
      STAT_UNKNOWN_ID,
      STAT_EXHAUSTED,
      STAT_EMPTY
   } stat_code_type;

   typedef enum logic [2:0] {
      CUR_HOLD,
      CUR_REQ,
      CUR_ORIGIN,
      CUR_REC,
      CUR_MOVE
   } cur_sel_type;

   typedef enum logic [1:0] {
      PAINT_ZERO,
      PAINT_NEW,
      PAINT_TARGET
   } paint_sel_type;

   typedef enum logic [1:0] {
      OWN_ZERO,
      OWN_NEW,
      OWN_TARGET,
      OWN_CELL
   } own_sel_type;

   typedef enum logic [1:0] {
      POS_ZERO,
      POS_CURSOR,
      POS_RECORD
   } pos_sel_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_DISPATCH,
      ST_WIPE,
      ST_FIT_RD,
      ST_FIT_CHK,
      ST_PAINT,
      ST_REC_WAIT,
      ST_LIVE_RD,
      ST_LIVE_CHK,
      ST_UNPAINT,
      ST_QRY_WAIT,
      ST_QRY_REC,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic          load;
      cur_sel_type   cur_sel;
      logic          off_clr;
      logic          off_step;
      logic          corner_step;
      logic          cell_rd_cur;
      logic          cell_rd_query;
      logic          paint_load;
      paint_sel_type paint_sel;
      logic          cell_wr;
      logic          sweep_clr;
      logic          sweep_step;
      logic          rec_rd_target;
      logic          rec_rd_cell;
      logic          rec_wr;
      logic          id_take;
      logic          occ_add;
      logic          occ_sub;
      logic          occ_clr;
      logic          res_wr;
      stat_code_type res_status;
      own_sel_type   res_owner;
      pos_sel_type   res_pos;
      logic          out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              cfg_wr;
      logic              out_free;
      logic              place_oob;
      logic              auto_oob;
      logic              move_oob;
      logic              query_oob;
      logic              tid_bad;
      logic              cell_zero;
      logic              cell_is_target;
      logic              off_last;
      logic              corner_last;
      logic              exhausted;
      logic              sweep_last;
   } dp_stat_type;

endpackage

// ===== rtl/core/grid_rectangle_allocator.sv =====
// ----------------------------------------------------------------------------
// grid_rectangle_allocator
// First-fit rectangle allocator over a two-dimensional grid of owned cells.
// ----------------------------------------------------------------------------
// The block takes one request word at a time and returns one result word for
// each. All work goes through the single read port of the cell owner memory:
// a fit test reads and checks each cell examined, painting or unpainting
// writes each cell, a remove or a move first checks the record's first cell,
// and a first-fit add repeats the fit test over the candidate corners. After
// reset, a clear request and every register write made while idle or
// sweeping, the block sweeps the whole cell memory, MAX_ROWS rounded up to a
// power of two times MAX_COLUMNS rounded likewise, and takes no request
// meanwhile. A finished result waits in an output register while the next
// request is accepted.
// ----------------------------------------------------------------------------
module grid_rectangle_allocator
   import gra_pkg::*;
#(
   parameter int MAX_COLUMNS = 16,
   parameter int MAX_ROWS    = 64,
   parameter int ID_BITS     = 12
)
(
   input  logic                  clock,
   input  logic                  reset,
   // func, pos_col, pos_row, rect_width, rect_height, target_id
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // status, owner_id, found_col, found_row, used_cells
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   gra_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   gra_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/gra_ctrl.sv =====
// ----------------------------------------------------------------------------
// gra_ctrl
// Controller of the grid rectangle allocator. Sequences clearing passes, fit
// scans, painting and record lookups by issuing commands to the datapath.
// ----------------------------------------------------------------------------
module gra_ctrl
   import gra_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_SWEEP: begin
            if (stat.cfg_wr) begin
               cmd.sweep_clr = 1'b1;
               cmd.occ_clr   = 1'b1;
            end else begin
               cmd.sweep_step = 1'b1;
               if (stat.sweep_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            req_tready = !stat.cfg_wr;
            if (stat.cfg_wr) begin
               cmd.sweep_clr = 1'b1;
               cmd.occ_clr   = 1'b1;
               state_in      = ST_SWEEP;
            end else if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.func) inside
               FUNC_PLACE: begin
                  if (stat.place_oob) begin
                     cmd.res_wr     = 1'b1;
                     cmd.res_status = STAT_BOUNDS;
                     state_in       = ST_FINISH;
                  end else begin
                     cmd.cur_sel = CUR_REQ;
                     cmd.off_clr = 1'b1;
                     state_in    = ST_FIT_RD;
                  end
               end
               FUNC_AUTO: begin
                  if (stat.auto_oob) begin
                     cmd.res_wr     = 1'b1;
                     cmd.res_status = STAT_BOUNDS;
                     state_in       = ST_FINISH;
                  end else begin
                     cmd.cur_sel = CUR_ORIGIN;
                     cmd.off_clr = 1'b1;
                     state_in    = ST_FIT_RD;
                  end
               end
               FUNC_REMOVE, FUNC_MOVE: begin
                  if (stat.tid_bad) begin
                     cmd.res_wr     = 1'b1;
                     cmd.res_status = STAT_UNKNOWN_ID;
                     state_in       = ST_FINISH;
                  end else begin
                     cmd.rec_rd_target = 1'b1;
                     state_in          = ST_REC_WAIT;
                  end
               end
               FUNC_QUERY: begin
                  if (stat.query_oob) begin
                     cmd.res_wr     = 1'b1;
                     cmd.res_status = STAT_BOUNDS;
                     state_in       = ST_FINISH;
                  end else begin
                     cmd.cell_rd_query = 1'b1;
                     state_in          = ST_QRY_WAIT;
                  end
               end
               FUNC_CLEAR: begin
                  cmd.sweep_clr = 1'b1;
                  cmd.occ_clr   = 1'b1;
                  state_in      = ST_WIPE;
               end
               default: begin
                  cmd.res_wr     = 1'b1;
                  cmd.res_status = STAT_OK;
                  state_in       = ST_FINISH;
               end
            endcase
         end
         ST_WIPE: begin
            cmd.sweep_step = 1'b1;
            if (stat.sweep_last) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = STAT_OK;
               state_in       = ST_FINISH;
            end
         end
         ST_FIT_RD: begin
            cmd.cell_rd_cur = 1'b1;
            state_in        = ST_FIT_CHK;
         end
         ST_FIT_CHK: begin
            if (!stat.cell_zero || (stat.off_last && stat.exhausted)) begin
               cmd.res_status = stat.cell_zero ? STAT_EXHAUSTED : STAT_NO_FIT;
               if (stat.func == FUNC_AUTO && !stat.cell_zero && !stat.corner_last) begin
                  cmd.corner_step = 1'b1;
                  cmd.off_clr     = 1'b1;
                  state_in        = ST_FIT_RD;
               end else if (stat.func == FUNC_MOVE) begin
                  cmd.res_wr     = 1'b1;
                  cmd.res_owner  = OWN_TARGET;
                  cmd.res_pos    = POS_RECORD;
                  cmd.cur_sel    = CUR_REC;
                  cmd.off_clr    = 1'b1;
                  cmd.paint_load = 1'b1;
                  cmd.paint_sel  = PAINT_TARGET;
                  state_in       = ST_PAINT;
               end else begin
                  cmd.res_wr = 1'b1;
                  state_in   = ST_FINISH;
               end
            end else if (!stat.off_last) begin
               cmd.off_step = 1'b1;
               state_in     = ST_FIT_RD;
            end else begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = STAT_OK;
               cmd.res_owner  = OWN_NEW;
               cmd.res_pos    = POS_CURSOR;
               cmd.id_take    = 1'b1;
               cmd.rec_wr     = 1'b1;
               cmd.paint_load = 1'b1;
               cmd.paint_sel  = PAINT_NEW;
               cmd.off_clr    = 1'b1;
               cmd.occ_add    = (stat.func != FUNC_MOVE);
               state_in       = ST_PAINT;
            end
         end
         ST_PAINT: begin
            cmd.cell_wr  = 1'b1;
            cmd.off_step = 1'b1;
            if (stat.off_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_REC_WAIT: begin
            cmd.cur_sel = CUR_REC;
            cmd.off_clr = 1'b1;
            state_in    = ST_LIVE_RD;
         end
         ST_LIVE_RD: begin
            cmd.cell_rd_cur = 1'b1;
            state_in        = ST_LIVE_CHK;
         end
         ST_LIVE_CHK: begin
            if (!stat.cell_is_target) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = STAT_UNKNOWN_ID;
               state_in       = ST_FINISH;
            end else begin
               cmd.paint_load = 1'b1;
               cmd.paint_sel  = PAINT_ZERO;
               state_in       = ST_UNPAINT;
               if (stat.func == FUNC_REMOVE) begin
                  cmd.res_wr     = 1'b1;
                  cmd.res_status = STAT_OK;
                  cmd.res_owner  = OWN_TARGET;
                  cmd.res_pos    = POS_RECORD;
                  cmd.occ_sub    = 1'b1;
               end
            end
         end
         ST_UNPAINT: begin
            cmd.cell_wr  = 1'b1;
            cmd.off_step = 1'b1;
            if (stat.off_last) begin
               if (stat.func == FUNC_REMOVE) begin
                  state_in = ST_FINISH;
               end else if (stat.move_oob) begin
                  cmd.res_wr     = 1'b1;
                  cmd.res_status = STAT_BOUNDS;
                  cmd.res_owner  = OWN_TARGET;
                  cmd.res_pos    = POS_RECORD;
                  cmd.cur_sel    = CUR_REC;
                  cmd.off_clr    = 1'b1;
                  cmd.paint_load = 1'b1;
                  cmd.paint_sel  = PAINT_TARGET;
                  state_in       = ST_PAINT;
               end else begin
                  cmd.cur_sel = CUR_MOVE;
                  cmd.off_clr = 1'b1;
                  state_in    = ST_FIT_RD;
               end
            end
         end
         ST_QRY_WAIT: begin
            if (stat.cell_zero) begin
               cmd.res_wr     = 1'b1;
               cmd.res_status = STAT_EMPTY;
               state_in       = ST_FINISH;
            end else begin
               cmd.rec_rd_cell = 1'b1;
               state_in        = ST_QRY_REC;
            end
         end
         ST_QRY_REC: begin
            cmd.res_wr     = 1'b1;
            cmd.res_status = STAT_OK;
            cmd.res_owner  = OWN_CELL;
            cmd.res_pos    = POS_RECORD;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/gra_datapath.sv =====
// ----------------------------------------------------------------------------
// gra_datapath
// Datapath of the grid rectangle allocator: grid size registers, cell owner
// memory, id record memory, rectangle cursor, id counter, occupancy count and
// the result output register.
// ----------------------------------------------------------------------------
module gra_datapath
   import gra_pkg::*;
#(
   parameter int MAX_COLUMNS = 16,
   parameter int MAX_ROWS    = 64,
   parameter int ID_BITS     = 12
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  dp_cmd_type             cmd,
   output dp_stat_type            stat,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata
);

   localparam int CA_BITS    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int RA_BITS    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CN_BITS    = $clog2(MAX_COLUMNS + 1);
   localparam int RN_BITS    = $clog2(MAX_ROWS + 1);
   localparam int CELL_AW    = CA_BITS + RA_BITS;
   localparam int CELL_DEPTH = 1 << CELL_AW;
   localparam int ID_DEPTH   = 1 << ID_BITS;
   localparam int REC_W      = CN_BITS + RN_BITS + CA_BITS + RA_BITS;
   localparam int OCC_BITS   = $clog2(MAX_COLUMNS * MAX_ROWS + 1);
   localparam int AREA_BITS  = CN_BITS + RN_BITS;
   localparam int COLS_RESET = (10 > MAX_COLUMNS) ? MAX_COLUMNS : 10;
   localparam int ROWS_RESET = (40 > MAX_ROWS) ? MAX_ROWS : 40;

   logic [FUNC_W-1:0]    func_ff;
   logic [POS_W-1:0]     pcol_ff;
   logic [POS_W-1:0]     prow_ff;
   logic [WID_W-1:0]     rw_ff;
   logic [HGT_W-1:0]     rh_ff;
   logic [TID_W-1:0]     tid_ff;

   logic [CN_BITS-1:0]   cols_ff;
   logic [CN_BITS-1:0]   cols_in;
   logic [RN_BITS-1:0]   rows_ff;
   logic [RN_BITS-1:0]   rows_in;

   logic [CA_BITS-1:0]   cur_col_ff;
   logic [CA_BITS-1:0]   cur_col_in;
   logic [RA_BITS-1:0]   cur_row_ff;
   logic [RA_BITS-1:0]   cur_row_in;
   logic [CN_BITS-1:0]   cur_w_ff;
   logic [CN_BITS-1:0]   cur_w_in;
   logic [RN_BITS-1:0]   cur_h_ff;
   logic [RN_BITS-1:0]   cur_h_in;
   logic [CA_BITS-1:0]   off_c_ff;
   logic [CA_BITS-1:0]   off_c_in;
   logic [RA_BITS-1:0]   off_r_ff;
   logic [RA_BITS-1:0]   off_r_in;

   logic [ID_BITS-1:0]   cell_mem [CELL_DEPTH];
   logic [ID_BITS-1:0]   cell_rdata_ff;
   logic [CELL_AW-1:0]   cell_raddr;
   logic [CELL_AW-1:0]   cell_waddr;
   logic [CELL_AW-1:0]   cur_addr;
   logic [ID_BITS-1:0]   cell_wdata;
   logic                 cell_we;
   logic [CELL_AW-1:0]   sweep_addr_ff;

   logic [REC_W-1:0]     rec_mem [ID_DEPTH];
   logic [REC_W-1:0]     rec_rdata_ff;
   logic [ID_BITS-1:0]   rec_raddr;
   logic [CN_BITS-1:0]   rec_w;
   logic [RN_BITS-1:0]   rec_h;
   logic [CA_BITS-1:0]   rec_col;
   logic [RA_BITS-1:0]   rec_row;

   logic [ID_BITS-1:0]   next_id_ff;
   logic [ID_BITS-1:0]   target_id;
   logic [ID_BITS-1:0]   paint_val_ff;
   logic [OCC_BITS-1:0]  occ_ff;
   logic [AREA_BITS-1:0] area;

   logic [STAT_W-1:0]    res_status_ff;
   logic [ID_BITS-1:0]   res_owner_ff;
   logic [ID_BITS-1:0]   res_owner_in;
   logic [CA_BITS-1:0]   res_col_ff;
   logic [CA_BITS-1:0]   res_col_in;
   logic [RA_BITS-1:0]   res_row_ff;
   logic [RA_BITS-1:0]   res_row_in;

   logic                 rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic                 col_next_fits;

   // Request word.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tdata[2:0];
         pcol_ff <= req_tdata[8:3];
         prow_ff <= req_tdata[14:9];
         rw_ff   <= req_tdata[19:15];
         rh_ff   <= req_tdata[26:20];
         tid_ff  <= req_tdata[38:27];
      end
   end

   // Grid size registers, saturated into the supported range.
   always_comb begin
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COLUMNS: begin
               if (csr_wdata[COLS_REG_W-1:0] == '0) begin
                  cols_in = CN_BITS'(1);
               end else if (SUM_W'(csr_wdata[COLS_REG_W-1:0]) > SUM_W'(MAX_COLUMNS)) begin
                  cols_in = CN_BITS'(MAX_COLUMNS);
               end else begin
                  cols_in = CN_BITS'(csr_wdata[COLS_REG_W-1:0]);
               end
            end
            default: begin
               if (csr_wdata[ROWS_REG_W-1:0] == '0) begin
                  rows_in = RN_BITS'(1);
               end else if (SUM_W'(csr_wdata[ROWS_REG_W-1:0]) > SUM_W'(MAX_ROWS)) begin
                  rows_in = RN_BITS'(MAX_ROWS);
               end else begin
                  rows_in = RN_BITS'(csr_wdata[ROWS_REG_W-1:0]);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= CN_BITS'(COLS_RESET);
         rows_ff <= RN_BITS'(ROWS_RESET);
      end else begin
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // Record fields of the last record read.
   assign rec_w   = rec_rdata_ff[CN_BITS-1:0];
   assign rec_h   = rec_rdata_ff[CN_BITS +: RN_BITS];
   assign rec_col = rec_rdata_ff[CN_BITS+RN_BITS +: CA_BITS];
   assign rec_row = rec_rdata_ff[CN_BITS+RN_BITS+CA_BITS +: RA_BITS];

   // Rectangle cursor.
   assign col_next_fits = (SUM_W'(cur_col_ff) + SUM_W'(cur_w_ff)) < SUM_W'(cols_ff);

   always_comb begin
      cur_col_in = cur_col_ff;
      cur_row_in = cur_row_ff;
      cur_w_in   = cur_w_ff;
      cur_h_in   = cur_h_ff;
      case (cmd.cur_sel)
         CUR_REQ: begin
            cur_col_in = CA_BITS'(pcol_ff);
            cur_row_in = RA_BITS'(prow_ff);
            cur_w_in   = CN_BITS'(rw_ff);
            cur_h_in   = RN_BITS'(rh_ff);
         end
         CUR_ORIGIN: begin
            cur_col_in = '0;
            cur_row_in = '0;
            cur_w_in   = CN_BITS'(rw_ff);
            cur_h_in   = RN_BITS'(rh_ff);
         end
         CUR_REC: begin
            cur_col_in = rec_col;
            cur_row_in = rec_row;
            cur_w_in   = rec_w;
            cur_h_in   = rec_h;
         end
         CUR_MOVE: begin
            cur_col_in = CA_BITS'(pcol_ff);
            cur_row_in = RA_BITS'(prow_ff);
            cur_w_in   = rec_w;
            cur_h_in   = rec_h;
         end
         default: begin
            if (cmd.corner_step) begin
               if (col_next_fits) begin
                  cur_col_in = cur_col_ff + CA_BITS'(1);
               end else begin
                  cur_col_in = '0;
                  cur_row_in = cur_row_ff + RA_BITS'(1);
               end
            end
         end
      endcase
   end

   always_comb begin
      off_c_in = off_c_ff;
      off_r_in = off_r_ff;
      if (cmd.off_clr) begin
         off_c_in = '0;
         off_r_in = '0;
      end else if (cmd.off_step) begin
         if (SUM_W'(off_c_ff) + SUM_W'(1) == SUM_W'(cur_w_ff)) begin
            off_c_in = '0;
            off_r_in = off_r_ff + RA_BITS'(1);
         end else begin
            off_c_in = off_c_ff + CA_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff <= cur_col_in;
      cur_row_ff <= cur_row_in;
      cur_w_ff   <= cur_w_in;
      cur_h_ff   <= cur_h_in;
      off_c_ff   <= off_c_in;
      off_r_ff   <= off_r_in;
   end

   // Cell owner memory.
   assign cur_addr = {RA_BITS'(cur_row_ff + off_r_ff), CA_BITS'(cur_col_ff + off_c_ff)};
   assign cell_raddr = cmd.cell_rd_query ? {RA_BITS'(prow_ff), CA_BITS'(pcol_ff)} : cur_addr;
   assign cell_we    = cmd.cell_wr || cmd.sweep_step;
   assign cell_waddr = cmd.sweep_step ? sweep_addr_ff : cur_addr;
   assign cell_wdata = cmd.sweep_step ? '0 : paint_val_ff;

   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wdata;
      end
      if (cmd.cell_rd_cur || cmd.cell_rd_query) begin
         cell_rdata_ff <= cell_mem[cell_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_addr_ff <= '0;
      end else if (cmd.sweep_clr) begin
         sweep_addr_ff <= '0;
      end else if (cmd.sweep_step) begin
         sweep_addr_ff <= sweep_addr_ff + CELL_AW'(1);
      end
   end

   // Id record memory.
   assign target_id = ID_BITS'(tid_ff);
   assign rec_raddr = cmd.rec_rd_target ? target_id : cell_rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.rec_wr) begin
         rec_mem[next_id_ff] <= {cur_row_ff, cur_col_ff, cur_h_ff, cur_w_ff};
      end
      if (cmd.rec_rd_target || cmd.rec_rd_cell) begin
         rec_rdata_ff <= rec_mem[rec_raddr];
      end
   end

   // Id counter, paint value and occupancy count.
   assign area = AREA_BITS'(cur_w_ff) * AREA_BITS'(cur_h_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         next_id_ff <= ID_BITS'(1);
         occ_ff     <= '0;
      end else begin
         if (cmd.id_take) begin
            next_id_ff <= next_id_ff + ID_BITS'(1);
         end
         if (cmd.occ_clr) begin
            occ_ff <= '0;
         end else if (cmd.occ_add) begin
            occ_ff <= occ_ff + OCC_BITS'(area);
         end else if (cmd.occ_sub) begin
            occ_ff <= occ_ff - OCC_BITS'(area);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.paint_load) begin
         case (cmd.paint_sel)
            PAINT_NEW:    paint_val_ff <= next_id_ff;
            PAINT_TARGET: paint_val_ff <= target_id;
            default:      paint_val_ff <= '0;
         endcase
      end
   end

   // Result fields.
   always_comb begin
      case (cmd.res_owner)
         OWN_NEW:    res_owner_in = next_id_ff;
         OWN_TARGET: res_owner_in = target_id;
         OWN_CELL:   res_owner_in = cell_rdata_ff;
         default:    res_owner_in = '0;
      endcase
      case (cmd.res_pos)
         POS_CURSOR: begin
            res_col_in = cur_col_ff;
            res_row_in = cur_row_ff;
         end
         POS_RECORD: begin
            res_col_in = rec_col;
            res_row_in = rec_row;
         end
         default: begin
            res_col_in = '0;
            res_row_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_wr) begin
         res_status_ff <= cmd.res_status;
         res_owner_ff  <= res_owner_in;
         res_col_ff    <= res_col_in;
         res_row_ff    <= res_row_in;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {4'd0, USED_W'(occ_ff), FROW_W'(res_row_ff), FCOL_W'(res_col_ff),
                         TID_W'(res_owner_ff), res_status_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Status toward the controller.
   always_comb begin
      stat.func      = func_ff;
      stat.cfg_wr    = csr_we;
      stat.out_free  = !rsp_valid_ff || rsp_tready;
      stat.place_oob = (rw_ff == '0) || (rh_ff == '0)
                       || (SUM_W'(pcol_ff) + SUM_W'(rw_ff) > SUM_W'(cols_ff))
                       || (SUM_W'(prow_ff) + SUM_W'(rh_ff) > SUM_W'(rows_ff));
      stat.auto_oob  = (rw_ff == '0) || (rh_ff == '0)
                       || (SUM_W'(rw_ff) > SUM_W'(cols_ff))
                       || (SUM_W'(rh_ff) > SUM_W'(rows_ff));
      stat.move_oob  = (rec_w == '0) || (rec_h == '0)
                       || (SUM_W'(pcol_ff) + SUM_W'(rec_w) > SUM_W'(cols_ff))
                       || (SUM_W'(prow_ff) + SUM_W'(rec_h) > SUM_W'(rows_ff));
      stat.query_oob = (SUM_W'(pcol_ff) >= SUM_W'(cols_ff))
                       || (SUM_W'(prow_ff) >= SUM_W'(rows_ff));
      stat.tid_bad   = (tid_ff == '0) || (17'(tid_ff) >= 17'(ID_DEPTH))
                       || (17'(tid_ff) >= 17'(next_id_ff));
      stat.cell_zero = (cell_rdata_ff == '0);
      stat.cell_is_target = (cell_rdata_ff == target_id);
      stat.off_last  = (SUM_W'(off_c_ff) + SUM_W'(1) == SUM_W'(cur_w_ff))
                       && (SUM_W'(off_r_ff) + SUM_W'(1) == SUM_W'(cur_h_ff));
      stat.corner_last = !col_next_fits
                       && (SUM_W'(cur_row_ff) + SUM_W'(cur_h_ff) >= SUM_W'(rows_ff));
      stat.exhausted = &next_id_ff;
      stat.sweep_last = &sweep_addr_ff;
   end

endmodule

// ===== rtl/core/gra_checker.sv =====
// ----------------------------------------------------------------------------
// gra_checker
// Port-level checks of the grid rectangle allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gra_checker
   import gra_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // The block is busy clearing its grid right after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid && !req_tready)
      else $error("response or ready seen right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[2:0] != 3'd6 && rsp_tdata[2:0] != 3'd7)
      else $error("undefined status code");

   // An empty cell reports no owner and no corner.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2:0] == STAT_EMPTY |-> rsp_tdata[24:3] == '0)
      else $error("empty cell reported with an owner");

   // Each accepted request keeps the block busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second word accepted back to back");

endmodule

bind grid_rectangle_allocator gra_checker u_gra_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== tb/grid_rectangle_allocator_tb.sv =====
// ----------------------------------------------------------------------------
// grid_rectangle_allocator_tb
// Self-checking testbench of the grid rectangle allocator. A directed sequence
// covers bounds, occupancy, unknown ids, failed moves, queries and clears. It
// is followed by random request words under several grid sizes and a short
// directed tail. A predictor of the grid computes each result word when its
// request word is accepted. The monitor compares the results field by field
// while the sender idles in bursts and the receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_rectangle_allocator_tb;
   import gra_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_USAGE = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;
   localparam int ID_TOP     = 4095;
   localparam int CYCLE_CAP  = 4000000;
   localparam int RAND_ITEMS = 92;

   typedef struct packed {
      logic              pad;
      logic [TID_W-1:0]  tid;
      logic [HGT_W-1:0]  h;
      logic [WID_W-1:0]  w;
      logic [POS_W-1:0]  row;
      logic [POS_W-1:0]  col;
      logic [FUNC_W-1:0] func;
   } req_word_t;

   typedef struct packed {
      logic [3:0]        pad;
      logic [USED_W-1:0] used;
      logic [FROW_W-1:0] frow;
      logic [FCOL_W-1:0] fcol;
      logic [TID_W-1:0]  owner;
      logic [STAT_W-1:0] status;
   } rsp_word_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   grid_rectangle_allocator dut (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Grid model.
   logic [TID_W-1:0] grid_owner [64][16];
   bit               id_alive [4096];
   int               rec_w [4096];
   int               rec_h [4096];
   int               rec_c [4096];
   int               rec_r [4096];
   int               ids_next = 1;
   int               used_count = 0;
   int               cols_active = 10;
   int               rows_active = 40;

   req_word_t pending_words [$];
   rsp_word_t expected_words [$];
   int        fail_count = 0;
   int        cycle_count = 0;

   function automatic void wipe_grid();
      for (int r = 0; r < 64; r++)
         for (int c = 0; c < 16; c++) grid_owner[r][c] = '0;
      for (int i = 0; i < 4096; i++) id_alive[i] = 1'b0;
      used_count = 0;
   endfunction

   function automatic int fit_test(int col, int row, int w, int h);
      if (w == 0 || h == 0 || col + w > cols_active || row + h > rows_active) return 1;
      for (int r = row; r < row + h; r++)
         for (int c = col; c < col + w; c++)
            if (grid_owner[r][c] != 0) return 2;
      return 0;
   endfunction

   function automatic void paint_rect(int col, int row, int w, int h, int id);
      for (int r = row; r < row + h && r < 64; r++)
         for (int c = col; c < col + w && c < 16; c++) grid_owner[r][c] = id[TID_W-1:0];
   endfunction

   function automatic int take_id(int col, int row, int w, int h);
      int id;
      id = ids_next;
      ids_next++;
      id_alive[id] = 1'b1;
      rec_w[id] = w;
      rec_h[id] = h;
      rec_c[id] = col;
      rec_r[id] = row;
      paint_rect(col, row, w, h, id);
      return id;
   endfunction

   function automatic void apply_setting(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      int v;
      if (idx == CSR_COLUMNS) begin
         v = val & 'h1f;
         cols_active = v < 1 ? 1 : (v > 16 ? 16 : v);
      end else begin
         v = val & 'h7f;
         rows_active = v < 1 ? 1 : (v > 64 ? 64 : v);
      end
      wipe_grid();
   endfunction

   function automatic rsp_word_t allocate_predict(req_word_t q);
      rsp_word_t res;
      int st, owner, fc, fr, col, row, w, h, tid, id, rw, rh, rc, rr;
      bit found;
      st = STAT_OK; owner = 0; fc = 0; fr = 0;
      col = q.col; row = q.row; w = q.w; h = q.h; tid = q.tid;
      found = 1'b0;
      case (q.func)
         FUNC_PLACE: begin
            st = fit_test(col, row, w, h);
            if (st == 0 && ids_next >= ID_TOP) st = STAT_EXHAUSTED;
            if (st == 0) begin
               owner = take_id(col, row, w, h);
               used_count += w * h;
               fc = col;
               fr = row;
            end
         end
         FUNC_AUTO: begin
            if (w == 0 || h == 0 || w > cols_active || h > rows_active) begin
               st = STAT_BOUNDS;
            end else begin
               for (int r = 0; r < rows_active && !found; r++)
                  for (int c = 0; c < cols_active && !found; c++)
                     if (fit_test(c, r, w, h) == 0) begin
                        found = 1'b1;
                        fc = c;
                        fr = r;
                     end
               if (!found) begin
                  st = STAT_NO_FIT;
               end else if (ids_next >= ID_TOP) begin
                  st = STAT_EXHAUSTED;
                  fc = 0;
                  fr = 0;
               end else begin
                  owner = take_id(fc, fr, w, h);
                  used_count += w * h;
               end
            end
         end
         FUNC_REMOVE, FUNC_MOVE: begin
            if (tid == 0 || !id_alive[tid]) begin
               st = STAT_UNKNOWN_ID;
            end else begin
               rw = rec_w[tid]; rh = rec_h[tid]; rc = rec_c[tid]; rr = rec_r[tid];
               paint_rect(rc, rr, rw, rh, 0);
               if (q.func == FUNC_REMOVE) begin
                  id_alive[tid] = 1'b0;
                  used_count -= rw * rh;
                  owner = tid;
                  fc = rc;
                  fr = rr;
               end else begin
                  st = fit_test(col, row, rw, rh);
                  if (st == 0 && ids_next >= ID_TOP) st = STAT_EXHAUSTED;
                  if (st == 0) begin
                     id_alive[tid] = 1'b0;
                     owner = take_id(col, row, rw, rh);
                     fc = col;
                     fr = row;
                  end else begin
                     paint_rect(rc, rr, rw, rh, tid);
                     owner = tid;
                     fc = rc;
                     fr = rr;
                  end
               end
            end
         end
         FUNC_QUERY: begin
            if (col >= cols_active || row >= rows_active) begin
               st = STAT_BOUNDS;
            end else begin
               id = grid_owner[row][col];
               if (id == 0) begin
                  st = STAT_EMPTY;
               end else begin
                  owner = id;
                  fc = rec_c[id];
                  fr = rec_r[id];
               end
            end
         end
         FUNC_CLEAR: wipe_grid();
         default: ;
      endcase
      res = '0;
      res.status = st[STAT_W-1:0];
      res.owner = owner[TID_W-1:0];
      res.fcol = fc[FCOL_W-1:0];
      res.frow = fr[FROW_W-1:0];
      res.used = used_count[USED_W-1:0];
      return res;
   endfunction

   // Sender: bursts of random length separated by random gaps.
   req_word_t word_on_bus;
   int        burst_left = 4;
   int        gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_words.insert(expected_words.size(), allocate_predict(word_on_bus));
            if (burst_left > 0) burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            end
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
               word_on_bus = pending_words.pop_front();
               req_tdata <= word_on_bus;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that changes its mode every so often.
   int stall_mode = 0;
   int mode_left = 0;
   rsp_word_t got;
   rsp_word_t want;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_words.size() == 0) begin
               $error("result word with nothing expected: %h", got);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               if (got.status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, got.status);
                  fail_count++;
               end
               if (got.owner !== want.owner) begin
                  $error("owner_id expected %0d actual %0d", want.owner, got.owner);
                  fail_count++;
               end
               if (got.fcol !== want.fcol) begin
                  $error("found_col expected %0d actual %0d", want.fcol, got.fcol);
                  fail_count++;
               end
               if (got.frow !== want.frow) begin
                  $error("found_row expected %0d actual %0d", want.frow, got.frow);
                  fail_count++;
               end
               if (got.used !== want.used) begin
                  $error("used_cells expected %0d actual %0d", want.used, got.used);
                  fail_count++;
               end
            end
         end
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 300);
         end else begin
            mode_left--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= $urandom_range(0, 1);
            2: rsp_tready <= ($urandom_range(0, 7) == 0);
            default: rsp_tready <= (cycle_count % 5) < 3;
         endcase
      end
   end

   always @(posedge clock) begin
      if (cycle_count >= CYCLE_CAP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic send(logic [FUNC_W-1:0] f, int col, int row, int w, int h, int tid);
      req_word_t q;
      q = '0;
      q.func = f;
      q.col = col[POS_W-1:0];
      q.row = row[POS_W-1:0];
      q.w = w[WID_W-1:0];
      q.h = h[HGT_W-1:0];
      q.tid = tid[TID_W-1:0];
      while (pending_words.size() >= 2) @(posedge clock);
      pending_words.insert(pending_words.size(), q);
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_words.size() != 0 || expected_words.size() != 0 || req_tvalid)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_setting(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_idle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      apply_setting(idx, val);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_random();
      int sel, col, row, w, h, tid;
      logic [FUNC_W-1:0] f;
      sel = $urandom_range(0, 99);
      if (sel < 30) f = FUNC_PLACE;
      else if (sel < 50) f = FUNC_AUTO;
      else if (sel < 65) f = FUNC_REMOVE;
      else if (sel < 80) f = FUNC_MOVE;
      else if (sel < 93) f = FUNC_QUERY;
      else if (sel < 95) f = FUNC_CLEAR;
      else if (sel < 98) f = FUNC_USAGE;
      else f = FUNC_SPARE;
      if ($urandom_range(0, 9) == 0) begin
         col = $urandom_range(0, 63);
         row = $urandom_range(0, 63);
      end else begin
         col = $urandom_range(0, cols_active);
         row = $urandom_range(0, rows_active);
      end
      if ($urandom_range(0, 9) == 0) begin
         w = $urandom_range(0, 31);
         h = $urandom_range(0, 127);
      end else begin
         w = $urandom_range(1, 4);
         h = $urandom_range(1, 6);
      end
      if ($urandom_range(0, 9) < 7 && ids_next > 1)
         tid = ids_next - $urandom_range(1, 6);
      else
         tid = $urandom_range(0, 4095);
      send(f, col, row, w, h, tid);
   endtask

   initial begin
      int base;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send(FUNC_PLACE, 0, 0, 3, 2, 0);
      send(FUNC_PLACE, 2, 1, 2, 2, 0);
      send(FUNC_PLACE, 8, 0, 3, 1, 0);
      send(FUNC_PLACE, 4, 4, 0, 2, 0);
      send(FUNC_PLACE, 4, 4, 2, 0, 0);
      send(FUNC_PLACE, 63, 63, 31, 127, 0);
      send(FUNC_AUTO, 0, 0, 2, 2, 0);
      send(FUNC_AUTO, 0, 0, 11, 1, 0);
      send(FUNC_AUTO, 0, 0, 10, 40, 0);
      send(FUNC_QUERY, 1, 1, 0, 0, 0);
      send(FUNC_QUERY, 9, 39, 0, 0, 0);
      send(FUNC_QUERY, 10, 0, 0, 0, 0);
      send(FUNC_MOVE, 5, 5, 0, 0, 1);
      send(FUNC_MOVE, 3, 0, 0, 0, 2);
      send(FUNC_MOVE, 9, 39, 0, 0, 2);
      send(FUNC_REMOVE, 0, 0, 0, 0, 0);
      send(FUNC_REMOVE, 0, 0, 0, 0, 4095);
      send(FUNC_REMOVE, 0, 0, 0, 0, 2);
      send(FUNC_REMOVE, 0, 0, 0, 0, 2);
      send(FUNC_USAGE, 0, 0, 0, 0, 0);
      send(FUNC_SPARE, 63, 63, 31, 127, 4095);
      send(FUNC_CLEAR, 0, 0, 0, 0, 0);
      send(FUNC_QUERY, 5, 5, 0, 0, 0);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_setting(CSR_COLUMNS, 7'd0); write_setting(CSR_ROWS, 7'd0); end
            1: begin write_setting(CSR_COLUMNS, 7'd31); write_setting(CSR_ROWS, 7'd127); end
            2: begin write_setting(CSR_COLUMNS, 7'd16); write_setting(CSR_ROWS, 7'd64); end
            3: begin write_setting(CSR_COLUMNS, 7'd1); write_setting(CSR_ROWS, 7'd5); end
            default: begin
               write_setting(CSR_COLUMNS, CSR_DATA_W'($urandom_range(0, 127)));
               write_setting(CSR_ROWS, CSR_DATA_W'($urandom_range(0, 127)));
            end
         endcase
         for (int i = 0; i < RAND_ITEMS; i++) begin
            if (phase == 2 && i == RAND_ITEMS / 2) wait_idle();
            send_random();
         end
      end

      // Place, then move a known rectangle around an occupied cell.
      write_setting(CSR_COLUMNS, 7'd8);
      wait_idle();
      base = ids_next;
      send(FUNC_PLACE, 5, 5, 1, 1, 0);
      send(FUNC_PLACE, 2, 2, 1, 1, 0);
      send(FUNC_AUTO, 0, 0, 1, 1, 0);
      send(FUNC_MOVE, 2, 2, 0, 0, base);
      send(FUNC_MOVE, 3, 3, 0, 0, base);
      send(FUNC_QUERY, 3, 3, 0, 0, 0);
      send(FUNC_MOVE, 7, 39, 0, 0, base);

      wait_idle();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== grid_rectangle_allocator.f =====
rtl/core/gra_pkg.sv
rtl/core/gra_ctrl.sv
rtl/core/gra_datapath.sv
rtl/core/grid_rectangle_allocator.sv
rtl/core/gra_checker.sv
tb/grid_rectangle_allocator_tb.sv
